/* design/binomial_variate_sampler_defines.svh */
// ----------------------------------------------------------------------------
// binomial variate sampler assertion macros
// shared property forms for the sampler's checks
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_VARIATE_SAMPLER_DEFINES_SVH
`define BINOMIAL_VARIATE_SAMPLER_DEFINES_SVH

// condition holds at every edge out of reset
`define BVS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// a condition implies another in the same cycle
`define BVS_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* design/bvs_pkg.sv */
// ----------------------------------------------------------------------------
// bvs_pkg
// constants, types and the log table builder for the binomial sampler
// ----------------------------------------------------------------------------
package bvs_pkg;

	localparam logic [34:0] LCG_MULT = 35'h5DEECE66D;
	localparam logic [47:0] LCG_ADD  = 48'hB;
	localparam logic [15:0] SEED_LOW = 16'h330E;
	localparam logic [23:0] LN2_Q24  = 24'd11629080;
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;
	localparam logic [31:0] LOG_MIN  = 32'h8000_0000;

	// log unit result word
	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} bvs_log_res_t;

	// ln(1 + k / 2^bits) in Q24, log2 by repeated squaring
	function automatic logic [31:0] ln_entry(input int k, input int bits);
		logic [63:0] y;
		logic [63:0] l2;
		logic [63:0] p;
		begin
			if (k == (1 << bits)) begin
				l2 = 64'd1 << 24;
			end else begin
				y  = (64'd1 << 30) + (64'(k) << (30 - bits));
				l2 = 64'd0;
				for (int i = 23; i >= 0; i--) begin
					y = (y * y) >> 30;
					if (y >= (64'd1 << 31)) begin
						y     = y >> 1;
						l2[i] = 1'b1;
					end
				end
			end
			p = l2 * 64'(LN2_Q32) + (64'd1 << 31);
			return p[63:32];
		end
	endfunction

endpackage

/* design/bvs_lcg.sv */
// ----------------------------------------------------------------------------
// bvs_lcg
// 48-bit linear congruential generator, multiply in three 16-bit slices
// ----------------------------------------------------------------------------
module bvs_lcg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [30:0] seed,
	input  logic        start,
	output logic        done,
	output logic [47:0] value
);
	import bvs_pkg::*;

	logic [47:0] state_q;
	logic [47:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] chunk;
	logic [50:0] pp;
	logic [65:0] pp_wide;
	logic [47:0] acc_next;

	// one partial product per cycle
	always_comb begin
		case (cnt_q)
			2'd0:    chunk = state_q[15:0];
			2'd1:    chunk = state_q[31:16];
			2'd2:    chunk = state_q[47:32];
			default: chunk = 16'd0;
		endcase
		pp       = 51'(chunk) * 51'(LCG_MULT);
		pp_wide  = {15'd0, pp} << {cnt_q, 4'd0};
		acc_next = acc_q + pp_wide[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= {32'd0, SEED_LOW};
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (seed_we) begin
				state_q <= {1'b0, seed, SEED_LOW};
			end
			if (start) begin
				acc_q  <= LCG_ADD;
				cnt_q  <= 2'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_next;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					state_q <= acc_next;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign value = state_q;

endmodule

/* design/bvs_log.sv */
// ----------------------------------------------------------------------------
// bvs_log
// natural log of v / 2^48 in Q8.24: bit-serial normalize, table, interpolate
// ----------------------------------------------------------------------------
module bvs_log #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [48:0]           v,
	output bvs_pkg::bvs_log_res_t res
);
	import bvs_pkg::*;

	localparam int TAB_SIZE = (1 << LOG_TABLE_BITS) + 1;

	localparam logic [2:0] LP_IDLE = 3'd0;
	localparam logic [2:0] LP_NORM = 3'd1;
	localparam logic [2:0] LP_TAB  = 3'd2;
	localparam logic [2:0] LP_MUL  = 3'd3;
	localparam logic [2:0] LP_SUM  = 3'd4;

	logic [31:0] ln_tab [TAB_SIZE];

	logic [2:0]                phase_q;
	logic [48:0]               v_q;
	logic [5:0]                e_q;
	logic [31:0]               lo_q;
	logic [23:0]               d_q;
	logic [15:0]               w_q;
	logic [31:0]               ipart_q;
	logic [23:0]               frac_q;
	logic [31:0]               res_q;
	logic                      done_q;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic [31:0]               lo;
	logic [31:0]               hi;
	logic signed [6:0]         eoff;
	logic [39:0]               dw;

	// constant ln(1 + f) table
	for (genvar k = 0; k < TAB_SIZE; k++) begin : g_tab
		assign ln_tab[k] = ln_entry(k, LOG_TABLE_BITS);
	end

	always_comb begin
		idx  = v_q[47 -: LOG_TABLE_BITS];
		lo   = ln_tab[{1'b0, idx}];
		hi   = ln_tab[{1'b0, idx} + (LOG_TABLE_BITS+1)'(1)];
		eoff = $signed({1'b0, e_q}) - 7'sd48;
		dw   = 40'(d_q) * 40'(w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				LP_IDLE: begin
					if (start) begin
						v_q     <= v;
						e_q     <= 6'd48;
						phase_q <= LP_NORM;
					end
				end
				// one bit of leading-one search per cycle
				LP_NORM: begin
					if (v_q[48]) begin
						phase_q <= LP_TAB;
					end else begin
						v_q <= v_q << 1;
						e_q <= e_q - 6'd1;
					end
				end
				LP_TAB: begin
					lo_q    <= lo;
					d_q     <= (hi >= lo) ? 24'(hi - lo) : 24'd0;
					w_q     <= v_q[47-LOG_TABLE_BITS -: 16];
					ipart_q <= 32'($signed(eoff) * $signed({1'b0, LN2_Q24}));
					phase_q <= LP_MUL;
				end
				LP_MUL: begin
					frac_q  <= dw[39:16];
					phase_q <= LP_SUM;
				end
				LP_SUM: begin
					res_q   <= ipart_q + lo_q + 32'(frac_q);
					done_q  <= 1'b1;
					phase_q <= LP_IDLE;
				end
				default: phase_q <= LP_IDLE;
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.value = res_q;

endmodule

/* design/bvs_div.sv */
// ----------------------------------------------------------------------------
// bvs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bvs_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= CW'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* design/binomial_variate_sampler.sv */
// A certain outcome (p >= 1.0 or zero trials) skips the rounds: the word goes from idle
// through the output state to the output register. Other words run rounds of generator, log
// unit (bit-serial normalizer of the 49-bit log argument) and restoring divider.
// One word at a time: input ready only while the sequencer is idle; a finished word
// waits in the output register while the next input word is taken.
// Reset clears control and loads the generator with the seed-zero value 0x330E.
// ----------------------------------------------------------------------------
// binomial_variate_sampler
// waiting-time binomial sampler sequencing a generator, log unit and divider
// ----------------------------------------------------------------------------
`include "binomial_variate_sampler_defines.svh"

module binomial_variate_sampler #(
	parameter int TRIALS_BITS    = 12,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   seed_we,
	input  logic [30:0]            seed,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TRIALS_BITS-1:0] trials,
	input  logic [16:0]            probability,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [TRIALS_BITS-1:0] successes
);
	import bvs_pkg::*;

	localparam int NUM_W = ((TRIALS_BITS > 32) ? TRIALS_BITS : 32) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOGQ = 3'd1;
	localparam logic [2:0] ST_DRAW = 3'd2;
	localparam logic [2:0] ST_LOGR = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam logic signed [33:0] SUM_FLOOR = -34'sd2147483648;

	logic [2:0]             state_q;
	logic [TRIALS_BITS-1:0] trials_q;
	logic [TRIALS_BITS-1:0] x_q;
	logic [TRIALS_BITS-1:0] res_q;
	logic signed [31:0]     logq_q;
	logic signed [31:0]     sum_q;
	logic                   out_valid_q;
	logic [TRIALS_BITS-1:0] successes_q;

	logic         lcg_start;
	logic         lcg_done;
	logic [47:0]  lcg_value;
	logic         log_start;
	logic [48:0]  log_v;
	bvs_log_res_t log_res;
	logic         div_start;
	logic [NUM_W-1:0] div_num;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	logic [31:0]            lr;
	logic [32:0]            neg_lr;
	logic [TRIALS_BITS-1:0] remain;
	logic signed [33:0]     new_sum;
	logic signed [31:0]     sum_sat;
	logic                   certain;

	bvs_lcg u_lcg (
		.clk     (clk),
		.arst_n  (arst_n),
		.seed_we (seed_we),
		.seed    (seed),
		.start   (lcg_start),
		.done    (lcg_done),
		.value   (lcg_value)
	);

	bvs_log #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.v      (log_v),
		.res    (log_res)
	);

	bvs_div #(
		.NUM_W (NUM_W),
		.DEN_W (TRIALS_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (remain),
		.done   (div_done),
		.quo    (div_quo)
	);

	// round datapath: clamp the log, ceil-divide, saturating sum
	always_comb begin
		certain = probability[16] || (trials == '0);
		if (state_q == ST_DRAW) begin
			lr = LOG_MIN;
		end else if (!log_res.value[31]) begin
			lr = 32'hFFFF_FFFF;
		end else begin
			lr = log_res.value;
		end
		neg_lr  = 33'(-$signed({lr[31], lr}));
		remain  = trials_q - x_q;
		div_num = NUM_W'(neg_lr) + NUM_W'(remain) - NUM_W'(1);
		new_sum = $signed({{2{sum_q[31]}}, sum_q}) - $signed({1'b0, 33'(div_quo)});
		sum_sat = (new_sum < SUM_FLOOR) ? $signed(LOG_MIN) : new_sum[31:0];
	end

	// unit start strobes
	always_comb begin
		log_start = 1'b0;
		log_v     = {1'b0, lcg_value};
		lcg_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				log_start = in_valid && !certain;
				log_v     = {17'd65536 - probability, 32'd0};
			end
			ST_LOGQ: lcg_start = log_res.done;
			ST_DRAW: begin
				if (lcg_done && (x_q != trials_q)) begin
					log_start = (lcg_value != '0);
					div_start = (lcg_value == '0);
				end
			end
			ST_LOGR: div_start = log_res.done;
			ST_DIV:  lcg_start = div_done && !(sum_sat < logq_q);
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			x_q         <= '0;
			trials_q    <= '0;
			sum_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						trials_q <= trials;
						x_q      <= '0;
						sum_q    <= '0;
						if (certain) begin
							res_q   <= trials;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_LOGQ;
						end
					end
				end
				ST_LOGQ: begin
					if (log_res.done) begin
						logq_q  <= log_res.value;
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (lcg_done) begin
						if (x_q == trials_q) begin
							res_q   <= x_q;
							state_q <= ST_OUT;
						end else if (lcg_value == '0) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_LOGR;
						end
					end
				end
				ST_LOGR: begin
					if (log_res.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						sum_q <= sum_sat;
						if (sum_sat < logq_q) begin
							res_q   <= x_q;
							state_q <= ST_OUT;
						end else begin
							x_q     <= x_q + TRIALS_BITS'(1);
							state_q <= ST_DRAW;
						end
					end
				end
				// hand the word to the output register
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						successes_q <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign successes = successes_q;

	`BVS_ASSERT_ALWAYS(a_x_in_range, x_q <= trials_q, "success count passed trial count")
	`BVS_ASSERT_ALWAYS(a_sum_nonpos, sum_q[31] || (sum_q == '0), "running sum went positive")
	`BVS_ASSERT_IMPL(a_log_owner, log_res.done, (state_q == ST_LOGQ) || (state_q == ST_LOGR), "log result with no waiter")
	`BVS_ASSERT_IMPL(a_div_owner, div_done, state_q == ST_DIV, "quotient with no waiter")

endmodule

/* bench/binomial_variate_sampler_test.sv */
// ----------------------------------------------------------------------------
// binomial_variate_sampler_test
// drives trial count and probability words into the sampler, predicts each
// binomial count with a fixed-point waiting-time model and a 48-bit generator
// copy, and checks every output word in order under random idling and stalls
// ----------------------------------------------------------------------------
module binomial_variate_sampler_test;
	import bvs_pkg::*;

	localparam int   TB_TRIALS_BITS = 12;
	localparam int   TAB_BITS       = 8;
	localparam int   RANDOM_WORDS   = 2000;
	localparam longint CYCLE_LIMIT  = 20_000_000;
	localparam longint Q24_FLOOR    = -64'sd2147483648;
	localparam logic [16:0] PROB_ONE = 17'd65536;

	// scoreboard: own generator copy, log table and queue of expected counts
	class binomial_scoreboard;
		longint                  ln_tab[0:(1 << TAB_BITS)];
		logic [47:0]             lcg;
		logic [TB_TRIALS_BITS-1:0] pending[$];
		int                      words_in;
		int                      words_out;

		function new();
			logic [63:0] y;
			logic [63:0] l2;
			logic [63:0] p;
			for (int k = 0; k <= (1 << TAB_BITS); k++) begin
				if (k == (1 << TAB_BITS)) begin
					l2 = 64'd1 << 24;
				end else begin
					y  = (64'd1 << 30) + (64'(k) << (30 - TAB_BITS));
					l2 = 64'd0;
					for (int i = 23; i >= 0; i--) begin
						y = (y * y) >> 30;
						if (y >= (64'd1 << 31)) begin
							y     = y >> 1;
							l2[i] = 1'b1;
						end
					end
				end
				p = l2 * 64'(LN2_Q32) + (64'd1 << 31);
				ln_tab[k] = longint'(p[63:32]);
			end
			lcg       = {32'd0, SEED_LOW};
			words_in  = 0;
			words_out = 0;
		endfunction

		function void reseed(logic [30:0] s);
			lcg = {1'b0, s, SEED_LOW};
		endfunction

		// natural log of v / 2^fbits in Q8.24, v nonzero
		function longint ln_q24(logic [63:0] v, int fbits);
			int          e;
			logic [63:0] frac;
			longint      lo;
			longint      hi;
			longint      d;
			longint      w;
			e = 63;
			while (e > 0 && v[e] == 1'b0)
				e--;
			frac = (v << (63 - e)) << 1;
			lo   = ln_tab[frac[63:56]];
			hi   = ln_tab[int'(frac[63:56]) + 1];
			w    = longint'(frac[55:40]);
			d    = hi - lo;
			if (d < 0)
				d = 0;
			return longint'(e - fbits) * longint'(LN2_Q24) + lo + ((d * w) >>> 16);
		endfunction

		function logic [47:0] draw();
			lcg = lcg * 48'(LCG_MULT) + LCG_ADD;
			return lcg;
		endfunction

		// accepted input word: run the waiting-time rounds
		function void note(logic [TB_TRIALS_BITS-1:0] t, logic [16:0] p);
			longint      log_q;
			longint      acc;
			longint      lr;
			longint      dv;
			longint      x;
			logic [47:0] r;
			words_in++;
			if (p >= PROB_ONE || t == 0) begin
				pending.push_back(t);
				return;
			end
			log_q = ln_q24(64'(PROB_ONE - p), 16);
			acc   = 0;
			x     = 0;
			forever begin
				r = draw();
				if (x >= longint'(t))
					break;
				if (r == 48'd0) begin
					lr = Q24_FLOOR;
				end else begin
					lr = ln_q24(64'(r), 48);
					if (lr > -1)
						lr = -1;
				end
				dv  = longint'(t) - x;
				acc = acc - ((-lr + dv - 1) / dv);
				if (acc < Q24_FLOOR)
					acc = Q24_FLOOR;
				if (acc < log_q)
					break;
				x++;
			end
			pending.push_back(x[TB_TRIALS_BITS-1:0]);
		endfunction

		// 0 match, 1 wrong count, 2 nothing expected
		function int check(logic [TB_TRIALS_BITS-1:0] got,
				output logic [TB_TRIALS_BITS-1:0] want);
			want = '0;
			if (pending.size() == 0)
				return 2;
			want = pending.pop_front();
			words_out++;
			return (got === want) ? 0 : 1;
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      seed_we;
	logic [30:0]               seed;
	logic                      in_valid;
	logic                      in_ready;
	logic [TB_TRIALS_BITS-1:0] trials;
	logic [16:0]               probability;
	logic                      out_valid;
	logic                      out_ready;
	logic [TB_TRIALS_BITS-1:0] successes;

	binomial_scoreboard count_board;
	int     errors;
	longint cycles = 0;
	int     send_idle;
	int     recv_idle;
	int     seeds_used;

	binomial_variate_sampler #(
		.TRIALS_BITS(TB_TRIALS_BITS),
		.LOG_TABLE_BITS(TAB_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.seed_we(seed_we),
		.seed(seed),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.trials(trials),
		.probability(probability),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.successes(successes)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// result monitor, sampled away from the active edge
	always @(negedge clk) begin
		logic [TB_TRIALS_BITS-1:0] want;
		int st;
		if (arst_n && out_valid && out_ready) begin
			st = count_board.check(successes, want);
			if (st == 2)
				report("unexpected word", successes, -1);
			else if (st == 1)
				report("successes", successes, want);
		end
	end

	// one input word with optional leading gap
	task automatic send_word(logic [TB_TRIALS_BITS-1:0] t, logic [16:0] p);
		logic rdy;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		trials      <= t;
		probability <= p;
		do begin
			@(negedge clk);
			rdy = in_ready;
			if (rdy)
				count_board.note(t, p);
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (count_board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_seed(logic [30:0] v);
		seed_we <= 1'b1;
		seed    <= v;
		@(posedge clk);
		seed_we <= 1'b0;
		count_board.reseed(v);
		seeds_used++;
		@(posedge clk);
	endtask

	// random word: mostly short runs, some full-width counts with tiny or certain probability
	task automatic send_random();
		logic [TB_TRIALS_BITS-1:0] t;
		logic [16:0]               p;
		int                        pick;
		pick = $urandom_range(99);
		if (pick < 5) begin
			t = TB_TRIALS_BITS'($urandom);
			p = PROB_ONE;
		end else if (pick < 15) begin
			t = TB_TRIALS_BITS'($urandom);
			p = 17'($urandom_range(16));
		end else begin
			t = TB_TRIALS_BITS'($urandom_range(15));
			p = 17'($urandom_range(65536));
		end
		send_word(t, p);
	endtask

	initial begin
		count_board = new();
		errors      = 0;
		seeds_used  = 0;
		send_idle   = 16;
		recv_idle   = 69;
		arst_n      = 1'b0;
		seed_we     = 1'b0;
		seed        = '0;
		in_valid    = 1'b0;
		trials      = '0;
		probability = '0;
		out_ready   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset seed
		send_word(12'd0, 17'd0);
		send_word(12'd0, PROB_ONE);
		send_word(12'd4095, PROB_ONE);
		send_word(12'd4095, 17'd0);
		send_word(12'd5, 17'd0);
		send_word(12'd1, 17'd65535);
		send_word(12'd1, 17'd1);
		send_word(12'd7, 17'd65535);
		send_word(12'd3, 17'd40000);
		send_word(12'd100, 17'd32768);
		send_word(12'd4095, 17'd1);
		send_word(12'd2730, 17'd21845);
		send_word(12'd4095, 17'd65535);
		// hold off until the sampler has emptied
		drain();

		write_seed(31'h7FFF_FFFF);
		send_word(12'd15, 17'd65535);
		send_word(12'd8, 17'd1);
		send_word(12'd12, 17'h0AAAA);
		send_word(12'd9, 17'h05555);
		drain();

		// random phases with changing idle mix and seeds
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 16;
					recv_idle = 69;
					write_seed(31'd0);
				end
				1: begin
					send_idle = 69;
					recv_idle = 16;
					write_seed(31'($urandom));
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					write_seed(31'd1);
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / 3; n++)
				send_random();
			drain();
		end

		$display("covered %0d input words over %0d seed settings in %0d cycles",
			count_board.words_in, seeds_used, cycles);
		$display("checked %0d output words, %0d mismatches", count_board.words_out, errors);
		if (errors == 0 && count_board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/bvs_pkg.sv
design/bvs_lcg.sv
design/bvs_log.sv
design/bvs_div.sv
design/binomial_variate_sampler.sv
bench/binomial_variate_sampler_test.sv
